// ----- rtl/core/tmfq_pkg.sv -----
package tmfq_pkg;

  localparam int CoordWidth = 32;
  localparam int QuatWidth  = 16;
  // Squared norm of a quaternion, and magnitude bound of every rotation numerator
  localparam int NormWidth  = 2 * QuatWidth + 1;
  // Signed width of a rotation numerator before taking its magnitude
  localparam int NumWidth   = NormWidth + 2;
  localparam int ProdWidth  = 2 * QuatWidth;
  localparam int HalfWidth  = CoordWidth / 2;
  localparam int HighWidth  = CoordWidth - HalfWidth;
  localparam int AccWidth   = NormWidth + CoordWidth + 1;
  localparam int Lanes      = 9;
  localparam int Axes       = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [QuatWidth-1:0]  quat_t;

  // One matrix entry on its way through the divider
  typedef struct packed {
    logic [NormWidth-1:0]  rem;
    logic [CoordWidth-1:0] lq;   // dividend bits shift out at the top, quotient bits in
    logic                  neg;
  } lane_t;

  typedef struct packed {
    logic                 valid;
    logic [NormWidth-1:0] norm;
    coord_t [Axes-1:0]    pos;
    lane_t [Lanes-1:0]    lane;
  } div_t;

endpackage

// ----- rtl/core/tmfq_if.sv -----
interface tmfq_in_if;
  import tmfq_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  quat_t  quat_w;
  quat_t  quat_x;
  quat_t  quat_y;
  quat_t  quat_z;
  coord_t scale_x;
  coord_t scale_y;
  coord_t scale_z;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface tmfq_out_if;
  import tmfq_pkg::*;

  logic   valid;
  logic   ready;
  coord_t m_r0c0;
  coord_t m_r0c1;
  coord_t m_r0c2;
  coord_t m_r0c3;
  coord_t m_r1c0;
  coord_t m_r1c1;
  coord_t m_r1c2;
  coord_t m_r1c3;
  coord_t m_r2c0;
  coord_t m_r2c1;
  coord_t m_r2c2;
  coord_t m_r2c3;

  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r0c3, m_r1c0, m_r1c1, m_r1c2,
                  m_r1c3, m_r2c0, m_r2c1, m_r2c2, m_r2c3, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r0c3, m_r1c0, m_r1c1, m_r1c2,
                m_r1c3, m_r2c0, m_r2c1, m_r2c2, m_r2c3, output ready);
endinterface

// ----- rtl/core/trs_model_matrix_from_quaternion_unit.sv -----
// An accepted word passes through 4 front stages, one divider stage per quotient bit
//   and 1 output stage on its way to the result word.
// Throughput: one word per cycle unless stalled; the restoring divider has 32 stages.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers are not reset.
module trs_model_matrix_from_quaternion_unit (
  input logic       clk_i,
  input logic       rst_ni,
  tmfq_in_if.sink   in_i,
  tmfq_out_if.source out_o
);
  import tmfq_pkg::*;

  localparam int Steps = CoordWidth;

  logic                  adv;
  div_t                  div_s [Steps+1];
  logic                  out_valid_q;
  coord_t [Lanes-1:0]    mat_q, mat_d;
  coord_t [Axes-1:0]     tr_q;
  logic [CoordWidth-1:0] quo;

  // advance every stage together whenever the output word can move on
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // products, numerators, rounded dividends
  tmfq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_i.valid),
    .pos_i    ({in_i.pos_z, in_i.pos_y, in_i.pos_x}),
    .quat_w_i (in_i.quat_w),
    .quat_x_i (in_i.quat_x),
    .quat_y_i (in_i.quat_y),
    .quat_z_i (in_i.quat_z),
    .scale_i  ({in_i.scale_z, in_i.scale_y, in_i.scale_x}),
    .stage_o  (div_s[0])
  );

  // one quotient bit per stage for all nine entries
  for (genvar k = 0; k < Steps; k++) begin : g_div
    tmfq_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (div_s[k]),
      .stage_o (div_s[k+1])
    );
  end

  // apply sign and saturate; the magnitude never exceeds the scale magnitude,
  // so only a positive 2^(w-1) needs clipping
  always_comb begin
    mat_d = '0;
    quo   = '0;
    for (int l = 0; l < Lanes; l++) begin
      quo = div_s[Steps].lane[l].lq;
      if (div_s[Steps].lane[l].neg) begin
        mat_d[l] = coord_t'(-quo);
      end else if (quo[CoordWidth-1]) begin
        mat_d[l] = coord_t'({1'b0, {(CoordWidth-1){1'b1}}});
      end else begin
        mat_d[l] = coord_t'(quo);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mat_q <= mat_d;
      tr_q  <= div_s[Steps].pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_s[Steps].valid;
    end
  end

  // entry index is row * 3 + column
  assign out_o.valid  = out_valid_q;
  assign out_o.m_r0c0 = mat_q[0];
  assign out_o.m_r0c1 = mat_q[1];
  assign out_o.m_r0c2 = mat_q[2];
  assign out_o.m_r0c3 = tr_q[0];
  assign out_o.m_r1c0 = mat_q[3];
  assign out_o.m_r1c1 = mat_q[4];
  assign out_o.m_r1c2 = mat_q[5];
  assign out_o.m_r1c3 = tr_q[1];
  assign out_o.m_r2c0 = mat_q[6];
  assign out_o.m_r2c1 = mat_q[7];
  assign out_o.m_r2c2 = mat_q[8];
  assign out_o.m_r2c3 = tr_q[2];

  // lane 0 remainder stays below the divisor at the divider's end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_s[Steps].valid |-> (div_s[Steps].lane[0].rem < div_s[Steps].norm))
    else $error("divider remainder out of range");

  // lane 4 quotient never exceeds 2^(w-1)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_s[Steps].valid |->
      (div_s[Steps].lane[4].lq <= {1'b1, {(CoordWidth-1){1'b0}}}))
    else $error("divider quotient out of range");

  // a stall freezes the last divider stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(div_s[Steps].valid) && $stable(div_s[Steps].lane[0].lq))
    else $error("pipeline moved during stall");

endmodule

// ----- rtl/core/tmfq_front.sv -----
module tmfq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  tmfq_pkg::coord_t [tmfq_pkg::Axes-1:0] pos_i,
  input  tmfq_pkg::quat_t  quat_w_i,
  input  tmfq_pkg::quat_t  quat_x_i,
  input  tmfq_pkg::quat_t  quat_y_i,
  input  tmfq_pkg::quat_t  quat_z_i,
  input  tmfq_pkg::coord_t [tmfq_pkg::Axes-1:0] scale_i,
  output tmfq_pkg::div_t  stage_o
);
  import tmfq_pkg::*;

  // stage 1: quaternion products
  logic                         s1_valid_q;
  logic signed [ProdWidth-1:0]  ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  coord_t [Axes-1:0]            s1_pos_q, s1_scale_q;
  quat_t                        w_eff;

  // stage 2: numerator magnitudes
  logic                         s2_valid_q;
  logic [NormWidth-1:0]         s2_norm_q, s2_norm_d;
  logic [NormWidth-1:0]         s2_mag_q [Lanes];
  logic [NormWidth-1:0]         s2_mag_d [Lanes];
  logic [Lanes-1:0]             s2_neg_q, s2_neg_d;
  logic [CoordWidth-1:0]        s2_smag_q [Axes];
  logic [CoordWidth-1:0]        s2_smag_d [Axes];
  coord_t [Axes-1:0]            s2_pos_q;
  logic signed [NumWidth-1:0]   nn, e [Lanes];
  logic signed [NumWidth-1:0]   sww, sxx, syy, szz, sxy, swz, sxz, swy, syz, swx;

  // stage 3: partial products
  logic                         s3_valid_q;
  logic [NormWidth+HalfWidth-1:0] pl_q [Lanes];
  logic [NormWidth+HighWidth-1:0] ph_q [Lanes];
  logic [NormWidth-1:0]         s3_norm_q;
  logic [Lanes-1:0]             s3_neg_q;
  coord_t [Axes-1:0]            s3_pos_q;

  // stage 4: rounded dividend, loaded into the divider word
  div_t                         s4_q, s4_d;
  logic                         s4_valid_q;
  logic [AccWidth-1:0]          acc [Lanes];

  // a zero quaternion turns into the identity
  assign w_eff = ((quat_w_i == '0) && (quat_x_i == '0) && (quat_y_i == '0) && (quat_z_i == '0))
                 ? QuatWidth'(1) : quat_w_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ww_q       <= ProdWidth'(w_eff) * ProdWidth'(w_eff);
      xx_q       <= ProdWidth'(quat_x_i) * ProdWidth'(quat_x_i);
      yy_q       <= ProdWidth'(quat_y_i) * ProdWidth'(quat_y_i);
      zz_q       <= ProdWidth'(quat_z_i) * ProdWidth'(quat_z_i);
      xy_q       <= ProdWidth'(quat_x_i) * ProdWidth'(quat_y_i);
      wz_q       <= ProdWidth'(w_eff) * ProdWidth'(quat_z_i);
      xz_q       <= ProdWidth'(quat_x_i) * ProdWidth'(quat_z_i);
      wy_q       <= ProdWidth'(w_eff) * ProdWidth'(quat_y_i);
      yz_q       <= ProdWidth'(quat_y_i) * ProdWidth'(quat_z_i);
      wx_q       <= ProdWidth'(w_eff) * ProdWidth'(quat_x_i);
      s1_pos_q   <= pos_i;
      s1_scale_q <= scale_i;
    end
  end

  always_comb begin
    sww = NumWidth'(ww_q);
    sxx = NumWidth'(xx_q);
    syy = NumWidth'(yy_q);
    szz = NumWidth'(zz_q);
    sxy = NumWidth'(xy_q);
    swz = NumWidth'(wz_q);
    sxz = NumWidth'(xz_q);
    swy = NumWidth'(wy_q);
    syz = NumWidth'(yz_q);
    swx = NumWidth'(wx_q);
    nn   = sww + sxx + syy + szz;
    e[0] = nn - ((syy + szz) <<< 1);
    e[1] = (sxy - swz) <<< 1;
    e[2] = (sxz + swy) <<< 1;
    e[3] = (sxy + swz) <<< 1;
    e[4] = nn - ((sxx + szz) <<< 1);
    e[5] = (syz - swx) <<< 1;
    e[6] = (sxz - swy) <<< 1;
    e[7] = (syz + swx) <<< 1;
    e[8] = nn - ((sxx + syy) <<< 1);
    s2_norm_d = nn[NormWidth-1:0];
    for (int a = 0; a < Axes; a++) begin
      s2_smag_d[a] = s1_scale_q[a][CoordWidth-1] ? CoordWidth'(-s1_scale_q[a])
                                                 : CoordWidth'(s1_scale_q[a]);
    end
    for (int l = 0; l < Lanes; l++) begin
      s2_mag_d[l] = e[l][NumWidth-1] ? NormWidth'(-e[l]) : NormWidth'(e[l]);
      s2_neg_d[l] = e[l][NumWidth-1] ^ s1_scale_q[l % Axes][CoordWidth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_norm_q <= s2_norm_d;
      s2_mag_q  <= s2_mag_d;
      s2_neg_q  <= s2_neg_d;
      s2_smag_q <= s2_smag_d;
      s2_pos_q  <= s1_pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int l = 0; l < Lanes; l++) begin
        pl_q[l] <= (NormWidth+HalfWidth)'(s2_mag_q[l])
                   * (NormWidth+HalfWidth)'(s2_smag_q[l % Axes][HalfWidth-1:0]);
        ph_q[l] <= (NormWidth+HighWidth)'(s2_mag_q[l])
                   * (NormWidth+HighWidth)'(s2_smag_q[l % Axes][CoordWidth-1:HalfWidth]);
      end
      s3_norm_q <= s2_norm_q;
      s3_neg_q  <= s2_neg_q;
      s3_pos_q  <= s2_pos_q;
    end
  end

  // add half the divisor so the truncating divider rounds half away from zero
  always_comb begin
    s4_d       = '0;
    s4_d.norm  = s3_norm_q;
    s4_d.pos   = s3_pos_q;
    for (int l = 0; l < Lanes; l++) begin
      acc[l] = AccWidth'(pl_q[l]) + (AccWidth'(ph_q[l]) << HalfWidth)
               + AccWidth'(s3_norm_q >> 1);
      s4_d.lane[l].rem = acc[l][CoordWidth+NormWidth-1:CoordWidth];
      s4_d.lane[l].lq  = acc[l][CoordWidth-1:0];
      s4_d.lane[l].neg = s3_neg_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_q <= s4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_comb begin
    stage_o       = s4_q;
    stage_o.valid = s4_valid_q;
  end

endmodule

// ----- rtl/core/tmfq_div_step.sv -----
module tmfq_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  tmfq_pkg::div_t stage_i,
  output tmfq_pkg::div_t stage_o
);
  import tmfq_pkg::*;

  div_t                 stage_q, stage_d;
  logic                 valid_q;
  logic [NormWidth:0]   trial [Lanes];
  logic                 fits  [Lanes];

  // one restoring step per lane: bring down a bit, subtract if it fits
  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < Lanes; l++) begin
      trial[l] = {stage_i.lane[l].rem, stage_i.lane[l].lq[CoordWidth-1]};
      fits[l]  = trial[l] >= {1'b0, stage_i.norm};
      stage_d.lane[l].rem = fits[l] ? NormWidth'(trial[l] - {1'b0, stage_i.norm})
                                    : NormWidth'(trial[l]);
      stage_d.lane[l].lq  = {stage_i.lane[l].lq[CoordWidth-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule
